// File: design/compute_unit_allocator_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the compute unit allocator.
// Each macro checks one implication on the rising clock edge, with the
// synchronous reset disabling the check.
// ---------------------------------------------------------------------------
`ifndef COMPUTE_UNIT_ALLOCATOR_UNIT_MACROS_SVH
`define COMPUTE_UNIT_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define CUA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define CUA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CUA_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CUA_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: design/cua_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Compute unit allocator package
// Shared constants, result codes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package cua_pkg;

  localparam int UNIT_COUNT = 16;
  localparam int IDX_W      = 4;   // width of unit_index and granted_unit
  localparam int LANE_W     = 8;
  localparam logic [LANE_W-1:0] LANE_WIDTH_RESET = 8'd65;

  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_WAIT      = 3'd1;
  localparam logic [2:0] ST_OWN_FREED = 3'd2;
  localparam logic [2:0] ST_NONE      = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;
  localparam logic [2:0] ST_ENABLED   = 3'd5;
  localparam logic [2:0] ST_IDLE      = 3'd6;

  typedef struct packed {
    logic             load_req;
    logic [IDX_W-1:0] idx;
    logic             write_grant;
    logic             clear_entry;
    logic             set_enable;
    logic             set_freed;
    logic             res_load;
    logic [2:0]       res_status;
    logic [IDX_W-1:0] res_unit;
    logic             out_load;
  } cua_cmd_t;

  typedef struct packed {
    logic             req_action;
    logic             req_first;
    logic [IDX_W-1:0] req_unit;
    logic             svc_in_range;
    logic             any_idle;
    logic [IDX_W-1:0] idle_idx;
    logic             repl_hit;
    logic             own_hit;
    logic             svc_release;
    logic             svc_enable;
    logic             freed;
    logic             out_free;
  } cua_stat_t;

endpackage
`default_nettype wire

// File: design/cua_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Compute unit allocator datapath
// Unit table, request and result registers, per-entry match logic and the
// output register.
// ---------------------------------------------------------------------------
`include "compute_unit_allocator_unit_macros.svh"
module cua_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cua_pkg::cua_cmd_t           cmd,
  output cua_pkg::cua_stat_t               stat,
  input  wire logic                        cfg_write,
  input  wire logic [cua_pkg::LANE_W-1:0]  cfg_lane_width,
  input  wire logic                        in_action,
  input  wire logic [15:0]                 in_read_id,
  input  wire logic [15:0]                 in_seg_id,
  input  wire logic                        in_first,
  input  wire logic [11:0]                 in_low_bound,
  input  wire logic [11:0]                 in_up_bound,
  input  wire logic [31:0]                 in_start_cycle,
  input  wire logic [31:0]                 in_end_cycle,
  input  wire logic [7:0]                  in_ram_block,
  input  wire logic [cua_pkg::IDX_W-1:0]   in_unit_index,
  input  wire logic [31:0]                 in_now_cycle,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2:0]                       out_status,
  output logic [cua_pkg::IDX_W-1:0]        out_unit
);
  import cua_pkg::*;

  logic [LANE_W-1:0] lane_width;

  // Unit table.
  logic [UNIT_COUNT-1:0] busy;
  logic [UNIT_COUNT-1:0] first_part;
  logic [UNIT_COUNT-1:0] main_en;
  logic [UNIT_COUNT-1:0] ext_en;
  logic [15:0] t_read_id    [UNIT_COUNT];
  logic [15:0] t_seg_id     [UNIT_COUNT];
  logic [11:0] t_low_bound  [UNIT_COUNT];
  logic [11:0] t_up_bound   [UNIT_COUNT];
  logic [31:0] t_start      [UNIT_COUNT];
  logic [31:0] t_end        [UNIT_COUNT];
  logic [7:0]  t_block      [UNIT_COUNT];

  // Registered request.
  logic             req_action;
  logic [15:0]      req_read_id;
  logic [15:0]      req_seg_id;
  logic             req_first;
  logic [11:0]      req_low_bound;
  logic [11:0]      req_up_bound;
  logic [31:0]      req_start;
  logic [31:0]      req_end;
  logic [7:0]       req_block;
  logic [IDX_W-1:0] req_unit;
  logic [31:0]      req_now;
  logic             freed;

  logic [2:0]       res_status;
  logic [IDX_W-1:0] res_unit;

  logic             idle_found;
  logic [IDX_W-1:0] idle_idx;

  // Lowest idle unit; the loop is reversed so that the lowest index wins.
  always_comb begin
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int u = UNIT_COUNT - 1; u >= 0; u--) begin
      if (!busy[u]) begin
        idle_found = 1'b1;
        idle_idx   = IDX_W'(u);
      end
    end
  end

  always_comb begin
    stat.req_action   = req_action;
    stat.req_first    = req_first;
    stat.req_unit     = req_unit;
    stat.svc_in_range = (32'(req_unit) < 32'(UNIT_COUNT));
    stat.any_idle     = idle_found;
    stat.idle_idx     = idle_idx;
    stat.repl_hit     = busy[cmd.idx] && first_part[cmd.idx] &&
                        (t_low_bound[cmd.idx] == 12'd0) &&
                        (t_up_bound[cmd.idx] <= {4'd0, lane_width});
    stat.own_hit      = busy[cmd.idx] && (t_read_id[cmd.idx] == req_read_id) &&
                        (t_seg_id[cmd.idx] == req_seg_id);
    // The end and start numbers minus one wrap modulo 2^32.
    stat.svc_release  = busy[cmd.idx] && (t_end[cmd.idx] - 32'd1 == req_now) &&
                        (main_en[cmd.idx] || ext_en[cmd.idx]);
    stat.svc_enable   = busy[cmd.idx] && (t_start[cmd.idx] - 32'd1 == req_now) &&
                        !main_en[cmd.idx] && !ext_en[cmd.idx];
    stat.freed        = freed;
    stat.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_action    <= in_action;
      req_read_id   <= in_read_id;
      req_seg_id    <= in_seg_id;
      req_first     <= in_first;
      req_low_bound <= in_low_bound;
      req_up_bound  <= in_up_bound;
      req_start     <= in_start_cycle;
      req_end       <= in_end_cycle;
      req_block     <= in_ram_block;
      req_unit      <= in_unit_index;
      req_now       <= in_now_cycle;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_unit   <= cmd.res_unit;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_unit   <= res_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_width <= LANE_WIDTH_RESET;
      out_valid  <= 1'b0;
      freed      <= 1'b0;
      busy       <= '0;
      first_part <= '0;
      main_en    <= '0;
      ext_en     <= '0;
      for (int u = 0; u < UNIT_COUNT; u++) begin
        t_read_id[u]   <= '0;
        t_seg_id[u]    <= '0;
        t_low_bound[u] <= '0;
        t_up_bound[u]  <= '0;
        t_start[u]     <= '0;
        t_end[u]       <= '0;
        t_block[u]     <= '0;
      end
    end else begin
      if (cfg_write) begin
        lane_width <= cfg_lane_width;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load_req) begin
        freed <= 1'b0;
      end else if (cmd.set_freed) begin
        freed <= 1'b1;
      end
      // A grant leaves both enables as they are: an idle unit already has
      // them clear, and a replaced unit keeps its own.
      if (cmd.write_grant) begin
        busy[cmd.idx]        <= 1'b1;
        first_part[cmd.idx]  <= req_first;
        t_read_id[cmd.idx]   <= req_read_id;
        t_seg_id[cmd.idx]    <= req_seg_id;
        t_low_bound[cmd.idx] <= req_low_bound;
        t_up_bound[cmd.idx]  <= req_up_bound;
        t_start[cmd.idx]     <= req_start;
        t_end[cmd.idx]       <= req_end;
        t_block[cmd.idx]     <= req_block;
      end
      if (cmd.clear_entry) begin
        busy[cmd.idx]        <= 1'b0;
        first_part[cmd.idx]  <= 1'b0;
        main_en[cmd.idx]     <= 1'b0;
        ext_en[cmd.idx]      <= 1'b0;
        t_read_id[cmd.idx]   <= '0;
        t_seg_id[cmd.idx]    <= '0;
        t_low_bound[cmd.idx] <= '0;
        t_up_bound[cmd.idx]  <= '0;
        t_start[cmd.idx]     <= '0;
        t_end[cmd.idx]       <= '0;
        t_block[cmd.idx]     <= '0;
      end
      if (cmd.set_enable) begin
        if (first_part[cmd.idx]) begin
          main_en[cmd.idx] <= 1'b1;
        end else begin
          ext_en[cmd.idx] <= 1'b1;
        end
      end
    end
  end

  `CUA_ASSERT_NXT(a_grant_sets_busy, clk, rst, cmd.write_grant, busy[$past(cmd.idx)], "granted unit not busy")
  `CUA_ASSERT_NXT(a_clear_frees, clk, rst, cmd.clear_entry, !busy[$past(cmd.idx)] && !main_en[$past(cmd.idx)], "cleared unit still held")
  `CUA_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !out_valid || out_ready, "pending result overwritten")

endmodule
`default_nettype wire

// File: design/cua_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Compute unit allocator controller
// Sequences one request: direct grant, wait answer, replacement scan,
// own-unit free scan or service, then hands the result word to the output register.
// ---------------------------------------------------------------------------
module cua_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cua_pkg::cua_stat_t stat,
  output cua_pkg::cua_cmd_t       cmd
);
  import cua_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_REPL  = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_SVC   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(UNIT_COUNT - 1);

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [IDX_W-1:0] scan;
  logic [IDX_W-1:0] scan_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    scan_next  = scan;
    cmd        = '0;
    cmd.idx    = scan;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          scan_next    = '0;
          state_next   = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (stat.req_action) begin
          state_next = S_SVC;
        end else if (stat.any_idle) begin
          cmd.idx         = stat.idle_idx;
          cmd.write_grant = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_status  = ST_GRANTED;
          cmd.res_unit    = stat.idle_idx;
          state_next      = S_DONE;
        end else if (stat.req_first) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_WAIT;
          state_next     = S_DONE;
        end else begin
          state_next = S_REPL;
        end
      end
      S_REPL: begin
        if (stat.repl_hit) begin
          cmd.write_grant = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_status  = ST_GRANTED;
          cmd.res_unit    = scan;
          state_next      = S_DONE;
        end else if (scan == LAST_IDX) begin
          scan_next  = '0;
          state_next = S_FREE;
        end else begin
          scan_next = scan + IDX_W'(1);
        end
      end
      S_FREE: begin
        if (stat.own_hit) begin
          cmd.clear_entry = 1'b1;
          cmd.set_freed   = 1'b1;
        end
        if (scan == LAST_IDX) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = (stat.freed || stat.own_hit) ? ST_OWN_FREED : ST_NONE;
          state_next     = S_DONE;
        end else begin
          scan_next = scan + IDX_W'(1);
        end
      end
      S_SVC: begin
        cmd.idx        = stat.req_unit;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_IDLE;
        if (stat.svc_in_range && stat.svc_release) begin
          cmd.clear_entry = 1'b1;
          cmd.res_status  = ST_RELEASED;
        end else if (stat.svc_in_range && stat.svc_enable) begin
          cmd.set_enable = 1'b1;
          cmd.res_status = ST_ENABLED;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scan  <= '0;
    end else begin
      state <= state_next;
      scan  <= scan_next;
    end
  end

endmodule
`default_nettype wire

// File: design/compute_unit_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Compute unit allocator
// Table of sixteen paired compute units with allocate and service requests.
// ---------------------------------------------------------------------------
// Usage:
// A request word enters on in_valid/in_ready and carries either an allocate
// (action 0) or a service of one unit (action 1). Exactly one result word
// (status, granted_unit) leaves on out_valid/out_ready for each request.
// The block handles one request at a time; in_ready is high only between
// requests. A direct grant or a wait answer is registered in the allocate
// state; a service passes through it to the service state. A replacement
// scan visits up to all sixteen entries and a following own-unit free scan
// all sixteen. A new request is taken in the cycle after the previous
// result word has been loaded into the output register.
// The scans read one table entry per cycle through a single read port.
// lane_width is written on cfg_valid/cfg_ready, which is always ready; write
// it only while no request is in flight, which the block does not enforce.
// Reset clears every unit, sets lane_width to 65 and drops out_valid.
// If the receiver stalls, the result word is held in the output register and
// the next request is still taken and worked on; its result waits until the
// output register is free.
// ---------------------------------------------------------------------------
module compute_unit_allocator_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       action,
  input  wire logic [15:0]                read_id,
  input  wire logic [15:0]                seg_id,
  input  wire logic                       is_first_part,
  input  wire logic [11:0]                low_bound,
  input  wire logic [11:0]                up_bound,
  input  wire logic [31:0]                start_cycle,
  input  wire logic [31:0]                end_cycle,
  input  wire logic [7:0]                 ram_block,
  input  wire logic [cua_pkg::IDX_W-1:0]  unit_index,
  input  wire logic [31:0]                now_cycle,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      status,
  output logic [cua_pkg::IDX_W-1:0]       granted_unit,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [cua_pkg::LANE_W-1:0] lane_width
);
  import cua_pkg::*;

  cua_cmd_t  cmd;
  cua_stat_t stat;

  assign cfg_ready = 1'b1;

  cua_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cua_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_lane_width (lane_width),
    .in_action      (action),
    .in_read_id     (read_id),
    .in_seg_id      (seg_id),
    .in_first       (is_first_part),
    .in_low_bound   (low_bound),
    .in_up_bound    (up_bound),
    .in_start_cycle (start_cycle),
    .in_end_cycle   (end_cycle),
    .in_ram_block   (ram_block),
    .in_unit_index  (unit_index),
    .in_now_cycle   (now_cycle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (status),
    .out_unit       (granted_unit)
  );

endmodule
`default_nettype wire

// File: tb/cua_tb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Compute unit allocator testbench package
// Request and answer word types, and a scoreboard that keeps its own copy of
// the unit table, predicts the answer to each accepted request and checks
// each answer word that leaves the block.
// ---------------------------------------------------------------------------
package cua_tb_pkg;
  import cua_pkg::*;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_SERVICE = 1'b1;

  typedef struct packed {
    logic             action;
    logic [15:0]      read_id;
    logic [15:0]      seg_id;
    logic             is_first_part;
    logic [11:0]      low_bound;
    logic [11:0]      up_bound;
    logic [31:0]      start_cycle;
    logic [31:0]      end_cycle;
    logic [7:0]       ram_block;
    logic [IDX_W-1:0] unit_index;
    logic [31:0]      now_cycle;
  } alloc_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] unit_no;
  } answer_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] read_id;
    logic [15:0] seg_id;
    logic [11:0] low_bound;
    logic [11:0] up_bound;
    logic        first_part;
    logic [31:0] start_cycle;
    logic [31:0] end_cycle;
    logic [7:0]  block;
    logic        main_en;
    logic        ext_en;
  } unit_entry_t;

  class alloc_scoreboard;
    unit_entry_t units [UNIT_COUNT];
    logic [LANE_W-1:0] lane_limit;
    answer_t due_answers [$];
    int errors;

    function new();
      lane_limit = LANE_WIDTH_RESET;
      foreach (units[u]) units[u] = '0;
      errors = 0;
    endfunction

    function void set_lane_limit(logic [LANE_W-1:0] value);
      lane_limit = value;
    endfunction

    function int pending();
      return due_answers.size();
    endfunction

    // A replacement keeps both enables; busy, identity, part, bounds, timing and block move.
    function void load_unit(int u, alloc_req_t r);
      units[u].busy        = 1'b1;
      units[u].read_id     = r.read_id;
      units[u].seg_id      = r.seg_id;
      units[u].first_part  = r.is_first_part;
      units[u].low_bound   = r.low_bound;
      units[u].up_bound    = r.up_bound;
      units[u].start_cycle = r.start_cycle;
      units[u].end_cycle   = r.end_cycle;
      units[u].block       = r.ram_block;
    endfunction

    function answer_t predict_answer(alloc_req_t r);
      answer_t a;
      bit done;
      bit freed;
      int idx;
      a.status  = ST_IDLE;
      a.unit_no = '0;
      done = 1'b0;
      if (r.action == ACT_ALLOC) begin
        for (int u = 0; u < UNIT_COUNT; u++) begin
          if (!done && !units[u].busy) begin
            load_unit(u, r);
            a.status  = ST_GRANTED;
            a.unit_no = IDX_W'(u);
            done = 1'b1;
          end
        end
        if (!done && r.is_first_part) begin
          a.status = ST_WAIT;
          done = 1'b1;
        end
        for (int u = 0; u < UNIT_COUNT; u++) begin
          if (!done && units[u].busy && units[u].first_part && units[u].low_bound == '0
              && units[u].up_bound <= lane_limit) begin
            load_unit(u, r);
            a.status  = ST_GRANTED;
            a.unit_no = IDX_W'(u);
            done = 1'b1;
          end
        end
        if (!done) begin
          freed = 1'b0;
          for (int u = 0; u < UNIT_COUNT; u++) begin
            if (units[u].busy && units[u].read_id == r.read_id
                && units[u].seg_id == r.seg_id) begin
              units[u] = '0;
              freed = 1'b1;
            end
          end
          a.status = freed ? ST_OWN_FREED : ST_NONE;
        end
      end else begin
        idx = int'(r.unit_index);
        if (idx < UNIT_COUNT && units[idx].busy) begin
          // The end or start cycle number minus one wraps round at the top of the cycle counter.
          if (units[idx].end_cycle - 32'd1 == r.now_cycle
              && (units[idx].main_en || units[idx].ext_en)) begin
            units[idx] = '0;
            a.status = ST_RELEASED;
          end else if (units[idx].start_cycle - 32'd1 == r.now_cycle
                       && !units[idx].main_en && !units[idx].ext_en) begin
            if (units[idx].first_part) units[idx].main_en = 1'b1;
            else units[idx].ext_en = 1'b1;
            a.status = ST_ENABLED;
          end
        end
      end
      return a;
    endfunction

    function void note_request(alloc_req_t r);
      answer_t a;
      a = predict_answer(r);
      due_answers = {due_answers, a};
    endfunction

    function void check_answer(logic [2:0] status, logic [IDX_W-1:0] unit_no);
      answer_t want;
      if (due_answers.size() == 0) begin
        $error("answer word with no request waiting: status %0d granted_unit %0d",
               status, unit_no);
        errors++;
        return;
      end
      want = due_answers.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (unit_no !== want.unit_no) begin
        $error("granted_unit: expected %0d, actual %0d", want.unit_no, unit_no);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/compute_unit_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Compute unit allocator testbench
// Drives allocate and service requests through the request channel, with a
// directed opening and random phases under several lane widths, and checks
// every answer word against a scoreboard that tracks the unit table.
// ---------------------------------------------------------------------------
module compute_unit_allocator_unit_tb;
  import cua_pkg::*;
  import cua_tb_pkg::*;

  localparam int PHASE_ITEMS    = 80;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AFTER     = 120;
  localparam int WATCHDOG_LIMIT = 4000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              action;
  logic [15:0]       read_id;
  logic [15:0]       seg_id;
  logic              is_first_part;
  logic [11:0]       low_bound;
  logic [11:0]       up_bound;
  logic [31:0]       start_cycle;
  logic [31:0]       end_cycle;
  logic [7:0]        ram_block;
  logic [IDX_W-1:0]  unit_index;
  logic [31:0]       now_cycle;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        status;
  logic [IDX_W-1:0]  granted_unit;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [LANE_W-1:0] lane_width;

  alloc_scoreboard sb;
  alloc_req_t directed_q [$];
  int burst_left;
  int answers_seen;

  compute_unit_allocator_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .read_id      (read_id),
    .seg_id       (seg_id),
    .is_first_part(is_first_part),
    .low_bound    (low_bound),
    .up_bound     (up_bound),
    .start_cycle  (start_cycle),
    .end_cycle    (end_cycle),
    .ram_block    (ram_block),
    .unit_index   (unit_index),
    .now_cycle    (now_cycle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_unit (granted_unit),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .lane_width   (lane_width)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] pick_cycle();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 1000));
      default: return $urandom;
    endcase
  endfunction

  function automatic alloc_req_t noise_request();
    alloc_req_t r;
    r.action        = $urandom_range(0, 1) ? ACT_SERVICE : ACT_ALLOC;
    r.read_id       = 16'($urandom);
    r.seg_id        = 16'($urandom);
    r.is_first_part = 1'($urandom);
    r.low_bound     = 12'($urandom);
    r.up_bound      = 12'($urandom);
    r.start_cycle   = $urandom;
    r.end_cycle     = $urandom;
    r.ram_block     = 8'($urandom);
    r.unit_index    = IDX_W'($urandom);
    r.now_cycle     = $urandom;
    return r;
  endfunction

  function automatic alloc_req_t alloc_req(logic first, logic [15:0] rid, logic [15:0] sid,
                                           logic [11:0] lo, logic [11:0] up,
                                           logic [31:0] t_start, logic [31:0] t_end,
                                           logic [7:0] blk);
    alloc_req_t r;
    r = noise_request();
    r.action        = ACT_ALLOC;
    r.is_first_part = first;
    r.read_id       = rid;
    r.seg_id        = sid;
    r.low_bound     = lo;
    r.up_bound      = up;
    r.start_cycle   = t_start;
    r.end_cycle     = t_end;
    r.ram_block     = blk;
    return r;
  endfunction

  function automatic alloc_req_t service_req(int idx, logic [31:0] now);
    alloc_req_t r;
    r = noise_request();
    r.action     = ACT_SERVICE;
    r.unit_index = IDX_W'(idx);
    r.now_cycle  = now;
    return r;
  endfunction

  function automatic void add_directed(alloc_req_t r);
    directed_q = {directed_q, r};
  endfunction

  // Identities come mostly from a small pool so that own-unit frees happen, and
  // services mostly aim at a busy unit's start or end so that it moves on.
  function automatic alloc_req_t random_request();
    alloc_req_t r;
    int busy_q [$];
    int idx;
    r = noise_request();
    if ($urandom_range(0, 99) < 10) return r;
    if ($urandom_range(0, 99) < 48) begin
      r.action = ACT_ALLOC;
      if ($urandom_range(0, 3) != 0) r.read_id = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 3) != 0) r.seg_id = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) r.low_bound = '0;
      if ($urandom_range(0, 1)) r.up_bound = 12'($urandom_range(0, 300));
      r.start_cycle = pick_cycle();
      r.end_cycle   = pick_cycle();
    end else begin
      r.action = ACT_SERVICE;
      for (int u = 0; u < UNIT_COUNT; u++)
        if (sb.units[u].busy) busy_q = {busy_q, u};
      if (busy_q.size() > 0 && $urandom_range(0, 9) < 8)
        r.unit_index = IDX_W'(busy_q[$urandom_range(0, busy_q.size() - 1)]);
      idx = int'(r.unit_index);
      if (sb.units[idx].busy && $urandom_range(0, 9) < 8) begin
        if ((sb.units[idx].main_en || sb.units[idx].ext_en) ^ ($urandom_range(0, 4) == 0))
          r.now_cycle = sb.units[idx].end_cycle - 32'd1;
        else
          r.now_cycle = sb.units[idx].start_cycle - 32'd1;
      end
    end
    return r;
  endfunction

  task automatic offer(input alloc_req_t r);
    in_valid      <= 1'b1;
    action        <= r.action;
    read_id       <= r.read_id;
    seg_id        <= r.seg_id;
    is_first_part <= r.is_first_part;
    low_bound     <= r.low_bound;
    up_bound      <= r.up_bound;
    start_cycle   <= r.start_cycle;
    end_cycle     <= r.end_cycle;
    ram_block     <= r.ram_block;
    unit_index    <= r.unit_index;
    now_cycle     <= r.now_cycle;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_phase(input int count, input bit use_directed);
    for (int i = 0; i < count; i++) begin
      offer(use_directed ? directed_q.pop_front() : random_request());
      if (i < count - 1) pace();
    end
    in_valid <= 1'b0;
  endtask

  // The margin leaves the block idle for a while before the next lane width.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_lane_width(input logic [LANE_W-1:0] value);
    cfg_valid  <= 1'b1;
    lane_width <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_lane_limit(value);
  endtask

  initial begin
    logic [LANE_W-1:0] widths [5];
    sb = new();
    widths = '{8'd1, 8'd65, 8'd255, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    burst_left    = 0;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    action        <= ACT_ALLOC;
    read_id       <= '0;
    seg_id        <= '0;
    is_first_part <= 1'b0;
    low_bound     <= '0;
    up_bound      <= '0;
    start_cycle   <= '0;
    end_cycle     <= '0;
    ram_block     <= '0;
    unit_index    <= '0;
    now_cycle     <= '0;
    cfg_valid     <= 1'b0;
    lane_width    <= LANE_WIDTH_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening: fill the table, then walk the wait, replace, none and own-free
    // answers, with enables surviving a replacement and a wrapped start cycle.
    write_lane_width(8'd255);
    add_directed(service_req(0, 32'h0));
    add_directed(alloc_req(1'b1, 16'd1, 16'd1, 12'd0, 12'd255, 32'd0, 32'd10, 8'h00));
    add_directed(service_req(0, 32'hFFFF_FFFF));
    for (int i = 1; i < UNIT_COUNT; i++)
      add_directed(alloc_req(i[0], i[0] ? 16'hFFFF : 16'd2,
                             i[0] ? 16'hFFFF : 16'(i), 12'hFFF, 12'hFFF,
                             32'hFFFF_FFFF, 32'h8000_0000, i[0] ? 8'hFF : 8'h55));
    add_directed(alloc_req(1'b1, 16'd5, 16'd5, 12'd0, 12'd0, 32'd1, 32'd2, 8'h12));
    add_directed(alloc_req(1'b0, 16'd3, 16'd3, 12'd0, 12'd0, 32'd20, 32'd30, 8'hA5));
    add_directed(service_req(0, 32'd19));
    add_directed(alloc_req(1'b0, 16'd3, 16'd4, 12'd0, 12'd0, 32'd5, 32'd6, 8'h5A));
    add_directed(alloc_req(1'b0, 16'hFFFF, 16'hFFFF, 12'd7, 12'd9, 32'd5, 32'd6,
                           8'h01));
    add_directed(service_req(0, 32'd29));
    add_directed(alloc_req(1'b1, 16'd0, 16'd0, 12'd0, 12'h041, 32'd0, 32'd0, 8'h80));
    send_phase(directed_q.size(), 1'b1);

    foreach (widths[p]) begin
      settle();
      write_lane_width(widths[p]);
      send_phase(PHASE_ITEMS, 1'b0);
    end
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // The receiver stalls on patterns of its own, and once holds off long enough
  // for the block to fill up and refuse further requests.
  initial begin
    int mode;
    int span_left;
    int hold_left;
    bit held;
    logic [7:0] pat;
    mode = 0;
    span_left = 0;
    hold_left = 0;
    held = 1'b0;
    pat = 8'h01;
    answers_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_answer(status, granted_unit);
        answers_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && answers_seen >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        if (span_left == 0) begin
          mode = $urandom_range(0, 2);
          pat = 8'($urandom) | 8'h01;
          span_left = $urandom_range(20, 80);
        end
        span_left--;
        pat = {pat[6:0], pat[7]};
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom);
          default: out_ready <= pat[0];
        endcase
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/cua_pkg.sv
design/cua_datapath.sv
design/cua_ctrl.sv
design/compute_unit_allocator_unit.sv
tb/cua_tb_pkg.sv
tb/compute_unit_allocator_unit_tb.sv
